[rtl/etd_pkg.sv]
// Shared constants for the Euler totient trial-division block.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package etd_pkg;

  // Width of the number and of its totient.
  localparam int unsigned NUMBER_BITS = 31;
  // Width of the bit counter of the shift-subtract divider.
  localparam int unsigned CNT_BITS    = $clog2(NUMBER_BITS);

  typedef logic [NUMBER_BITS-1:0] num_t;

endpackage

`default_nettype wire

[rtl/euler_totient_trial_division.sv]
// Euler totient by trial division, sequenced around one shift-subtract divider.
// Depends on etd_pkg for the operand width.
//
// Usage: a request on the input channel (in_valid_i, in_stall_o, number_i)
// carries one number; one result (out_valid_o, out_stall_i, totient_o) follows.
// The block works on one request at a time and raises in_stall_o from the
// cycle after acceptance until the result has been written to the output
// register. The result may still be waiting there while the next request is
// taken.
// Sequence: factors of two are shifted out at one bit a cycle. Every trial
// divisor then costs one division in the shared divider, and each prime found
// costs one further division of the running result, one per extra power and
// one more to see that no power is left. About 23 000 odd trial divisors lie
// below the square root of 2^31, so a large prime takes longest; small or
// smooth numbers finish far sooner.
// A number of zero returns zero, going straight from idle to the done state.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties
// the output register. While the receiver stalls, the result stays put and a
// finished computation waits for the output register to free.
`default_nettype none

module euler_totient_trial_division (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [etd_pkg::NUMBER_BITS-1:0] number_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [etd_pkg::NUMBER_BITS-1:0] totient_o
);

  localparam int unsigned W = etd_pkg::NUMBER_BITS;
  localparam etd_pkg::num_t FirstOdd = etd_pkg::num_t'(3);
  localparam etd_pkg::num_t OddStep  = etd_pkg::num_t'(2);
  localparam etd_pkg::num_t TwoVal   = etd_pkg::num_t'(2);
  localparam logic [etd_pkg::CNT_BITS-1:0] LastBit = etd_pkg::CNT_BITS'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_EVAL,
    ST_FINAL,
    ST_DONE
  } state_e;

  // What the current division is for.
  typedef enum logic [1:0] {
    MD_TEST,
    MD_APPLY,
    MD_REDUCE,
    MD_LAST
  } mode_e;

  state_e                      state_q;
  mode_e                       mode_q;
  etd_pkg::num_t               acc_q;
  etd_pkg::num_t               rem_q;
  etd_pkg::num_t               dvs_q;
  etd_pkg::num_t               div_rem_q;
  etd_pkg::num_t               div_quo_q;
  etd_pkg::num_t               div_dvs_q;
  logic [etd_pkg::CNT_BITS-1:0] cnt_q;
  logic                        out_valid_q;
  etd_pkg::num_t               totient_q;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          sub_ok;
  etd_pkg::num_t dvs_next;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial    = {div_rem_q, div_quo_q[W-1]};
    diff     = trial - {1'b0, div_dvs_q};
    sub_ok   = ~diff[W];
    dvs_next = dvs_q + OddStep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MD_TEST;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // In the done state the output register is handled by that state alone.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            rem_q <= number_i;
            if (number_i == '0) begin
              acc_q   <= '0;
              state_q <= ST_DONE;
            end else begin
              // An even number has the prime two: halve the result once.
              acc_q   <= number_i[0] ? number_i : number_i - (number_i >> 1);
              state_q <= ST_STRIP;
            end
          end
        end
        ST_STRIP: begin
          if (rem_q[0]) begin
            dvs_q     <= FirstOdd;
            div_rem_q <= '0;
            div_quo_q <= rem_q;
            div_dvs_q <= FirstOdd;
            cnt_q     <= '0;
            mode_q    <= MD_TEST;
            state_q   <= ST_DIV;
          end else begin
            rem_q <= rem_q >> 1;
          end
        end
        ST_DIV: begin
          div_rem_q <= sub_ok ? diff[W-1:0] : trial[W-1:0];
          div_quo_q <= {div_quo_q[W-2:0], sub_ok};
          cnt_q     <= cnt_q + 1'b1;
          if (cnt_q == LastBit) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          // Each arm either finishes the loop or launches the next division.
          div_rem_q <= '0;
          cnt_q     <= '0;
          state_q   <= ST_DIV;
          unique case (mode_q)
            MD_TEST: begin
              if (dvs_q > div_quo_q) begin
                state_q <= ST_FINAL;
              end else if (div_rem_q == '0) begin
                rem_q     <= div_quo_q;
                div_quo_q <= acc_q;
                div_dvs_q <= dvs_q;
                mode_q    <= MD_APPLY;
              end else begin
                dvs_q     <= dvs_next;
                div_quo_q <= rem_q;
                div_dvs_q <= dvs_next;
              end
            end
            MD_APPLY: begin
              // The division is exact, so acc/p*(p-1) equals acc - acc/p.
              acc_q     <= acc_q - div_quo_q;
              div_quo_q <= rem_q;
              div_dvs_q <= dvs_q;
              mode_q    <= MD_REDUCE;
            end
            MD_REDUCE: begin
              if (div_rem_q == '0) begin
                rem_q     <= div_quo_q;
                div_quo_q <= div_quo_q;
                div_dvs_q <= dvs_q;
              end else begin
                dvs_q     <= dvs_next;
                div_quo_q <= rem_q;
                div_dvs_q <= dvs_next;
                mode_q    <= MD_TEST;
              end
            end
            MD_LAST: begin
              acc_q   <= acc_q - div_quo_q;
              state_q <= ST_DONE;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_FINAL: begin
          // A remainder above two is one last prime factor.
          if (rem_q > TwoVal) begin
            div_rem_q <= '0;
            div_quo_q <= acc_q;
            div_dvs_q <= rem_q;
            cnt_q     <= '0;
            mode_q    <= MD_LAST;
            state_q   <= ST_DIV;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            totient_q   <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign totient_o   = totient_q;

endmodule

`default_nettype wire

[rtl/etd_checker.sv]
// Port-level checks for the Euler totient block, bound to its top level.
// Depends on etd_pkg for the operand width.
`default_nettype none

module etd_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [etd_pkg::NUMBER_BITS-1:0] totient_o
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(totient_o))
    else $error("stalled result changed or vanished");

  // Once a request is taken the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without the block going busy");

  // A new result only appears at the end of a computation.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

  // Leaving the busy state always hands over a result.
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block went idle without presenting a result");

endmodule

bind euler_totient_trial_division etd_checker u_etd_checker (.*);

`default_nettype wire
